// File: rtl/core/plsu_pkg.sv
// Package for the positional list store: payload structs, request and status codes,
// the cell command struct and the sizing functions of the read tree.
// No dependencies.
`default_nettype none

package plsu_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int POS_W         = 7;
    localparam int ENTRY_W       = 7;
    localparam int TREE_RADIX    = 4;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_ERASE  = 2'd1,
        MODE_READ   = 2'd2
    } mode_e;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN,
        S_RESULT
    } state_e;

    typedef struct packed {
        logic [1:0]              mode;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] item_value;
    } in_item_t;

    typedef struct packed {
        status_e                  status;
        logic signed [DATA_W-1:0] read_value;
        logic [ENTRY_W-1:0]       entry_count;
    } out_item_t;

    // Command broadcast to every cell during the execute cycle.
    typedef struct packed {
        logic              exec;
        logic              ins;
        logic              era;
        logic              rd;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

    // Number of nodes at a given level of the read tree; level zero is the cells.
    function automatic int level_nodes(input int depth, input int lvl);
        int n;
        n = depth;
        for (int k = 0; k < lvl; k++) begin
            n = (n + TREE_RADIX - 1) / TREE_RADIX;
        end
        return n;
    endfunction

    function automatic int tree_levels(input int depth);
        int l;
        l = 0;
        for (int k = 0; k < 32; k++) begin
            if (level_nodes(depth, k) > 1) begin
                l = k + 1;
            end
        end
        return l;
    endfunction

    // Index of the first node of a level in the flattened node array.
    function automatic int node_offset(input int depth, input int lvl);
        int s;
        s = 0;
        for (int k = 0; k < lvl; k++) begin
            s = s + level_nodes(depth, k);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/positional_list_store_unit.sv
// Positional list store: an ordered store of signed 32-bit entries with insert, erase and read
// by position. A transaction on the s_ channel carries one request; each request produces exactly
// one result transaction on the m_ channel with a status, the value read and the entry count.
// The entries live in a row of DEPTH identical cells; an insert moves every cell above the
// position up by one from its left neighbour and an erase moves those at and above it down
// from the right, all in the execute cycle. A read selects the addressed cell and gathers its
// value through a registered radix-4 OR tree of ceil(log4(DEPTH)) levels. One request is
// handled at a time: it is accepted in the idle cycle, executes in the next, then waits in the
// drain state while the read passes each tree level and hands the result to the output
// register in the result state before the block returns to idle, so the depth of the read
// tree sets how often requests can be accepted. The output register lets a new request be
// accepted while the previous result is still waiting on m_ready; if it is still waiting
// when the next result is ready, the block holds that result until the register frees.
// Positions are 7 bits wide and the entry count is reported modulo 128, so depths above 128
// are only partly addressable. Reset (aresetn, synchronous, active low) empties the store at
// once; the entry contents are not cleared and are never read before being written. Depends
// on plsu_pkg, plsu_cell, plsu_read_tree and plsu_ctrl.
`default_nettype none

module positional_list_store_unit
    import plsu_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    cell_cmd_t         cmd;
    logic [DATA_W-1:0] cell_val [DEPTH];
    logic [DATA_W-1:0] cell_tap [DEPTH];
    logic [DATA_W-1:0] root;

    // Sequencer: owns the entry count, the request and the result register.
    plsu_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .root    (root)
    );

    // The chain of cells. The ends see zero as their missing neighbour, which only ever
    // lands in a slot at or above the entry count.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] left_val;
        logic [DATA_W-1:0] right_val;

        if (i == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_left
            assign left_val = cell_val[i - 1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_right
            assign right_val = cell_val[i + 1];
        end

        plsu_cell #(
            .DEPTH(DEPTH),
            .IDX  (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (cell_val[i]),
            .tap       (cell_tap[i])
        );
    end

    // Read gathering: only the addressed cell drives a non-zero tap.
    plsu_read_tree #(
        .DEPTH(DEPTH)
    ) u_read_tree (
        .aclk (aclk),
        .taps (cell_tap),
        .root (root)
    );

endmodule

`default_nettype wire

// File: rtl/core/plsu_cell.sv
// One storage cell of the list chain: holds a single entry and shifts with its neighbours.
// Depends on plsu_pkg.
`default_nettype none

module plsu_cell
    import plsu_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX   = 0
) (
    input  wire logic              aclk,
    input  wire cell_cmd_t         cmd,
    input  wire logic [DATA_W-1:0] left_val,
    input  wire logic [DATA_W-1:0] right_val,
    output logic      [DATA_W-1:0] val,
    output logic      [DATA_W-1:0] tap
);

    localparam int IDX_W = $clog2(DEPTH) + 1;
    localparam int CMP_W = (POS_W > IDX_W) ? POS_W : IDX_W;

    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] tap_reg, tap_next;
    logic [CMP_W-1:0]  idx_c;
    logic [CMP_W-1:0]  pos_c;
    logic              at_pos;
    logic              above_pos;

    assign idx_c     = CMP_W'(IDX);
    assign pos_c     = CMP_W'(cmd.pos);
    assign at_pos    = (idx_c == pos_c);
    assign above_pos = (idx_c > pos_c);

    always_comb begin
        val_next = val_reg;
        if (cmd.ins) begin
            if (at_pos) begin
                val_next = cmd.value;
            end else if (above_pos) begin
                val_next = left_val;
            end
        end else if (cmd.era && (at_pos || above_pos)) begin
            val_next = right_val;
        end
    end

    // The tap keeps what it captured in the execute cycle so the tree output stays steady.
    always_comb begin
        tap_next = tap_reg;
        if (cmd.exec) begin
            tap_next = (cmd.rd && at_pos) ? val_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        tap_reg <= tap_next;
    end

    assign val = val_reg;
    assign tap = tap_reg;

endmodule

`default_nettype wire

// File: rtl/core/plsu_read_tree.sv
// Registered OR-reduction tree that gathers the single selected cell tap into one word.
// Depends on plsu_pkg.
`default_nettype none

module plsu_read_tree
    import plsu_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic [DATA_W-1:0] taps [DEPTH],
    output logic      [DATA_W-1:0] root
);

    localparam int LEVELS = tree_levels(DEPTH);
    localparam int TOTAL  = node_offset(DEPTH, LEVELS + 1);

    logic [DATA_W-1:0] nodes [TOTAL];

    for (genvar t = 0; t < DEPTH; t++) begin : g_leaf
        assign nodes[t] = taps[t];
    end

    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        localparam int N      = level_nodes(DEPTH, l);
        localparam int NP     = level_nodes(DEPTH, l - 1);
        localparam int OFF    = node_offset(DEPTH, l);
        localparam int OFF_P  = node_offset(DEPTH, l - 1);

        for (genvar n = 0; n < N; n++) begin : g_node
            logic [TREE_RADIX-1:0][DATA_W-1:0] kids;
            logic [DATA_W-1:0]                 acc;

            for (genvar c = 0; c < TREE_RADIX; c++) begin : g_kid
                if (TREE_RADIX * n + c < NP) begin : g_used
                    assign kids[c] = nodes[OFF_P + TREE_RADIX * n + c];
                end else begin : g_pad
                    assign kids[c] = '0;
                end
            end

            always_comb begin
                acc = '0;
                for (int c = 0; c < TREE_RADIX; c++) begin
                    acc = acc | kids[c];
                end
            end

            always_ff @(posedge aclk) begin
                nodes[OFF + n] <= acc;
            end
        end
    end

    assign root = nodes[TOTAL - 1];

endmodule

`default_nettype wire

// File: rtl/core/plsu_ctrl.sv
// Request sequencer: decodes each transaction against the entry count, drives the cell
// command, waits out the read tree and holds the result register. Depends on plsu_pkg.
`default_nettype none

module plsu_ctrl
    import plsu_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data,
    output cell_cmd_t              cmd,
    input  wire logic [DATA_W-1:0] root
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int LEVELS = tree_levels(DEPTH);
    localparam int DRN_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    state_e             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DRN_W-1:0]   drain_reg, drain_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;
    in_item_t           req_reg, req_next;
    status_e            pend_status_reg, pend_status_next;
    logic [ENTRY_W-1:0] pend_count_reg, pend_count_next;

    logic               accept;
    logic               in_exec;
    logic               out_free;
    logic               out_load;
    logic               drain_last;

    logic [CMP_W-1:0]   pos_c;
    logic [CMP_W-1:0]   cnt_c;
    logic               cnt_zero;
    logic               dec_ins;
    logic               dec_era;
    logic               dec_rd;
    logic [POS_W-1:0]   dec_pos;
    status_e            dec_status;
    logic [CNT_W-1:0]   dec_count;

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign drain_last = (drain_reg == DRN_W'(LEVELS - 1));

    // Decode of the held request against the current count.
    assign pos_c    = CMP_W'(req_reg.position);
    assign cnt_c    = CMP_W'(count_reg);
    assign cnt_zero = (count_reg == '0);

    always_comb begin
        dec_ins    = 1'b0;
        dec_era    = 1'b0;
        dec_rd     = 1'b0;
        dec_pos    = req_reg.position;
        dec_status = ST_BADPOS;
        dec_count  = count_reg;
        case (req_reg.mode)
            MODE_INSERT: begin
                if (cnt_zero) begin
                    dec_ins    = 1'b1;
                    dec_pos    = '0;
                    dec_status = ST_OK;
                    dec_count  = CNT_W'(1);
                end else if (pos_c > cnt_c) begin
                    dec_status = ST_BADPOS;
                end else if (cnt_c >= CMP_W'(DEPTH)) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_ins    = 1'b1;
                    dec_status = ST_OK;
                    dec_count  = count_reg + CNT_W'(1);
                end
            end
            MODE_ERASE: begin
                if (cnt_zero) begin
                    dec_status = ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    dec_status = ST_BADPOS;
                end else begin
                    dec_era    = 1'b1;
                    dec_status = ST_OK;
                    dec_count  = count_reg - CNT_W'(1);
                end
            end
            MODE_READ: begin
                if (cnt_zero) begin
                    dec_status = ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    dec_status = ST_BADPOS;
                end else begin
                    dec_rd     = 1'b1;
                    dec_status = ST_OK;
                end
            end
            default: begin
                dec_status = ST_BADPOS;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (drain_last) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        s_ready  = 1'b0;
        in_exec  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_EXEC: begin
                in_exec = 1'b1;
            end
            S_DRAIN: begin
                s_ready = 1'b0;
            end
            S_RESULT: begin
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        cmd.exec  = in_exec;
        cmd.ins   = in_exec && dec_ins;
        cmd.era   = in_exec && dec_era;
        cmd.rd    = in_exec && dec_rd;
        cmd.pos   = dec_pos;
        cmd.value = req_reg.item_value;
    end

    always_comb begin
        count_next       = in_exec ? dec_count : count_reg;
        pend_status_next = in_exec ? dec_status : pend_status_reg;
        pend_count_next  = in_exec ? ENTRY_W'(dec_count) : pend_count_reg;
        drain_next       = (state_reg == S_DRAIN) ? drain_reg + DRN_W'(1) : '0;
        req_next         = accept ? s_data : req_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg;
        if (out_load) begin
            m_valid_next            = 1'b1;
            m_data_next.status      = pend_status_reg;
            m_data_next.read_value  = root;
            m_data_next.entry_count = pend_count_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            drain_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            drain_reg   <= drain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg         <= req_next;
        pend_status_reg <= pend_status_next;
        pend_count_reg  <= pend_count_next;
        m_data_reg      <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("entry count exceeds the store depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("successful insert did not grow the count by one");

    a_erase_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.era |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("successful erase did not shrink the count by one");

    a_ops_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ins || cmd.era || cmd.rd) |-> ($onehot({cmd.ins, cmd.era, cmd.rd}) && in_exec))
        else $error("cell command issued outside the execute cycle or not unique");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DRAIN && pend_status_reg == ST_FULL)
            |-> (CMP_W'(count_reg) == CMP_W'(DEPTH)))
        else $error("full status reported while the store has room");

endmodule

`default_nettype wire

// File: tb/tb_positional_list_store_unit.sv
// Self-checking testbench for positional_list_store_unit: directed and random insert, erase,
// read and spare-code transactions, checked against a behavioural model of the ordered store.
// Depends on plsu_pkg and the positional_list_store_unit RTL.
`default_nettype none

module tb_positional_list_store_unit;
    import plsu_pkg::*;

    localparam int          STORE_DEPTH   = 64;
    localparam int          RANDOM_ITEMS  = 1880;
    localparam int          HOLD_START    = 400;     // requests accepted before the long hold-off
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 20;
    localparam longint      CYCLE_LIMIT   = 500000;
    localparam logic [1:0]  MODE_SPARE    = 2'd3;    // undefined request code
    localparam logic [6:0]  POS_TOP       = 7'd127;

    // Pending request together with the idle cycles the sender inserts ahead of it.
    typedef struct {
        in_item_t req;
        int       gap;
    } stim_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    positional_list_store_unit #(.DEPTH(STORE_DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------------------------------
    // Behavioural model of the store. The entries and the count are updated once per accepted
    // request transaction, and the answer that the block must give is returned.
    // ------------------------------------------------------------------------------------------
    logic signed [31:0] list_mem [STORE_DEPTH];
    int                 list_len = 0;
    int                 full_hits = 0;
    int                 empty_hits = 0;

    function automatic out_item_t apply_request(input in_item_t req);
        out_item_t res;
        int        p;
        p = int'(req.position);
        res.status      = ST_OK;
        res.read_value  = '0;
        case (req.mode)
            MODE_INSERT: begin
                if (list_len == 0) begin
                    // An empty store takes an insert at any position as its first entry.
                    list_mem[0] = req.item_value;
                    list_len    = 1;
                end else if (p > list_len) begin
                    res.status = ST_BADPOS;
                end else if (list_len >= STORE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > p; i--) begin
                        list_mem[i] = list_mem[i-1];
                    end
                    list_mem[p] = req.item_value;
                    list_len++;
                    if (list_len == STORE_DEPTH) begin
                        full_hits++;
                    end
                end
            end
            MODE_ERASE: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p >= list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (int i = p; i + 1 < list_len; i++) begin
                        list_mem[i] = list_mem[i+1];
                    end
                    list_len--;
                    if (list_len == 0) begin
                        empty_hits++;
                    end
                end
            end
            MODE_READ: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (p >= list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.read_value = list_mem[p];
                end
            end
            default: begin
                // The spare request code changes nothing and is reported as a bad position.
                res.status = ST_BADPOS;
            end
        endcase
        res.entry_count = ENTRY_W'(list_len);
        return res;
    endfunction

    // ------------------------------------------------------------------------------------------
    // Stimulus generation. The generator keeps a rough running length of its own so that it can
    // aim positions at the live part of the store; the checking never relies on it.
    // ------------------------------------------------------------------------------------------
    stim_t pending [$];
    int    gen_len = 0;

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic int receiver_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_request(input logic [1:0] mode, input int pos,
                                 input logic signed [31:0] value, input int gap);
        stim_t s;
        s.req.mode       = mode;
        s.req.position   = POS_W'(pos);
        s.req.item_value = value;
        s.gap            = gap;
        pending.push_back(s);
        // Track the length the generator expects, only to steer later positions.
        if (mode == MODE_INSERT) begin
            if (gen_len == 0) begin
                gen_len = 1;
            end else if (pos <= gen_len && gen_len < STORE_DEPTH) begin
                gen_len++;
            end
        end else if (mode == MODE_ERASE && gen_len > 0 && pos < gen_len) begin
            gen_len--;
        end
    endtask

    // Position for a request: mostly inside the live range, sometimes on its edges and
    // sometimes beyond it, up to the largest value the field can hold.
    function automatic int pick_position(input logic [1:0] mode);
        int r;
        int top;
        top = (mode == MODE_INSERT) ? gen_len : gen_len - 1;
        r = $urandom_range(0, 99);
        if (top < 0 || r < 10) begin
            return $urandom_range(top + 1, int'(POS_TOP));
        end else if (r < 20) begin
            return ($urandom_range(0, 1) == 0) ? 0 : top;
        end
        return $urandom_range(0, top);
    endfunction

    task automatic build_directed();
        // Requests on an empty store, including the largest position.
        queue_request(MODE_READ,   0,   32'sd0, 0);
        queue_request(MODE_ERASE,  0,   32'sd0, 0);
        queue_request(MODE_READ,   int'(POS_TOP), 32'sd0, 2);
        // An insert on an empty store ignores its position.
        queue_request(MODE_INSERT, 100, 32'sh7FFF_FFFF, 0);
        queue_request(MODE_READ,   0,   32'sd0, 0);
        queue_request(MODE_READ,   1,   32'sd0, 1);
        queue_request(MODE_INSERT, 2,   32'sd5, 0);              // beyond the count
        queue_request(MODE_INSERT, 1,   32'sh8000_0000, 0);      // at the count, appends
        queue_request(MODE_INSERT, 0,   -32'sd1, 3);             // at the front
        queue_request(MODE_INSERT, 1,   32'sd0, 0);              // in the middle
        for (int i = 0; i < 4; i++) begin
            queue_request(MODE_READ, i, $urandom(), 0);
        end
        queue_request(MODE_ERASE,  4,   32'sd0, 0);
        queue_request(MODE_ERASE,  int'(POS_TOP), 32'sd0, 0);
        queue_request(MODE_SPARE,  0,   32'sh1234_5678, 0);
        queue_request(MODE_SPARE,  int'(POS_TOP), -32'sd1, 0);
        queue_request(MODE_ERASE,  3,   32'sd0, 0);              // last entry
        queue_request(MODE_ERASE,  0,   32'sd0, 1);              // first entry
        queue_request(MODE_ERASE,  0,   32'sd0, 0);
        queue_request(MODE_ERASE,  0,   32'sd0, 0);              // the only entry
        queue_request(MODE_READ,   0,   32'sd0, 0);
    endtask

    // Random phases: growing phases drive the store to full, shrinking ones drain it to empty,
    // mixed phases work it in between and noise phases throw arbitrary codes and positions.
    task automatic build_random();
        int          made;
        int          kind;
        int          span;
        int          quiet;
        int          r;
        logic [1:0]  mode;
        made = 0;
        while (made < RANDOM_ITEMS) begin
            kind  = $urandom_range(0, 3);
            span  = $urandom_range(40, 120);
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < span && made < RANDOM_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                case (kind)
                    0:       mode = (r < 70) ? MODE_INSERT : (r < 80) ? MODE_ERASE :
                                    (r < 97) ? MODE_READ : MODE_SPARE;
                    1:       mode = (r < 70) ? MODE_ERASE : (r < 80) ? MODE_INSERT :
                                    (r < 97) ? MODE_READ : MODE_SPARE;
                    2:       mode = (r < 35) ? MODE_INSERT : (r < 65) ? MODE_ERASE :
                                    (r < 97) ? MODE_READ : MODE_SPARE;
                    default: mode = 2'($urandom_range(0, 3));
                endcase
                queue_request(mode,
                              (kind == 3) ? $urandom_range(0, int'(POS_TOP))
                                          : pick_position(mode),
                              pick_value(),
                              quiet ? 0 : sender_gap());
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------------------------------
    // Sender. Inputs change on the falling edge. A transaction that has been offered is held,
    // payload unchanged, until the rising edge at which it is accepted.
    // ------------------------------------------------------------------------------------------
    logic  s_taken = 1'b0;
    logic  m_taken = 1'b0;
    stim_t cur_stim;
    logic  have_next = 1'b0;
    int    tx_wait = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_taken)) begin
            if (!have_next && pending.size() > 0) begin
                cur_stim  = pending.pop_front();
                have_next = 1'b1;
                tx_wait   = cur_stim.gap;
            end
            if (have_next && tx_wait == 0) begin
                s_data    <= cur_stim.req;
                s_valid   <= 1'b1;
                have_next = 1'b0;
            end else begin
                s_valid <= 1'b0;
                if (have_next) begin
                    tx_wait--;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------------
    // Receiver. m_ready stalls at random after each result transaction; every so often a whole
    // stretch runs with no stalls at all. The long hold-off below overrides everything.
    // ------------------------------------------------------------------------------------------
    logic rx_hold = 1'b0;
    int   rx_wait = 0;
    int   n_results = 0;

    always @(negedge aclk) begin
        int w;
        if (!aresetn || rx_hold) begin
            m_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            m_ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else if (m_taken) begin
            w = ((n_results / 150) % 4 == 3) ? 0 : receiver_stall();
            m_ready <= (w == 0);
            rx_wait <= (w == 0) ? 0 : w - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------------------------
    // Monitor and scoreboard, on the rising edge. Accepted requests run through the model and
    // their answers wait in order; each accepted result is checked against the oldest one.
    // ------------------------------------------------------------------------------------------
    out_item_t answers_due [$];
    int        n_requests = 0;
    int        n_errors = 0;
    int        status_seen [4] = '{0, 0, 0, 0};
    int        input_stall_cycles = 0;
    longint    cycle_count = 0;

    always @(posedge aclk) begin
        out_item_t want;
        cycle_count <= cycle_count + 1;
        s_taken <= aresetn && s_valid && s_ready;
        m_taken <= aresetn && m_valid && m_ready;
        if (aresetn) begin
            if (rx_hold && s_valid && !s_ready) begin
                input_stall_cycles++;
            end
            if (s_valid && s_ready) begin
                answers_due.push_back(apply_request(s_data));
                n_requests++;
            end
            if (m_valid && m_ready) begin
                n_results++;
                status_seen[m_data.status]++;
                if (answers_due.size() == 0) begin
                    $error("result transaction with no request outstanding: status %0d",
                           m_data.status);
                    n_errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        n_errors++;
                    end
                    if (m_data.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, m_data.read_value);
                        n_errors++;
                    end
                    if (m_data.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, m_data.entry_count);
                        n_errors++;
                    end
                end
            end
        end
    end

    // A hung handshake ends the run here rather than running forever.
    always @(posedge aclk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering: the output register and the held
    // result fill up and the block must drop s_ready until the receiver resumes.
    initial begin
        while (n_requests < HOLD_START) begin
            @(negedge aclk);
        end
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------------------------
    // Test sequence: build the stimulus, reset once, let the driver run dry, then wait for the
    // last answers and a short drain to catch any stray result.
    // ------------------------------------------------------------------------------------------
    initial begin
        build_directed();
        build_random();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending.size() > 0 || have_next || s_valid) begin
            @(posedge aclk);
        end
        while (answers_due.size() > 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (answers_due.size() != 0) begin
            $error("%0d expected results never arrived", answers_due.size());
            n_errors++;
        end

        $display("%0d requests, %0d results: ok %0d, bad position %0d, empty %0d, full %0d.",
                 n_requests, n_results, status_seen[ST_OK], status_seen[ST_BADPOS],
                 status_seen[ST_EMPTY], status_seen[ST_FULL]);
        $display("Store filled %0d times and drained %0d times; input held off for %0d cycles.",
                 full_hits, empty_hits, input_stall_cycles);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/plsu_pkg.sv
rtl/core/plsu_cell.sv
rtl/core/plsu_read_tree.sv
rtl/core/plsu_ctrl.sv
rtl/core/positional_list_store_unit.sv
tb/tb_positional_list_store_unit.sv
